FILE: sv/mmpc_pkg.sv
// package for the markov matrix power block: sizes, types, controller states
// used by the controller, datapath and top level
package mmpc_pkg;

  localparam int unsigned MaxStates = 8;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned IdxW      = $clog2(MaxStates);
  localparam int unsigned CellW     = 2 * IdxW;
  localparam int unsigned Cells     = MaxStates * MaxStates;
  localparam int unsigned ValW      = FracBits + 1;
  localparam int unsigned AccW      = ValW + IdxW + 1;
  localparam int unsigned DistW     = ValW + CellW + 1;
  localparam int unsigned EpsW      = 21;
  localparam int unsigned MaxPowW   = 7;
  localparam int unsigned SizeW     = 4;
  localparam int unsigned PowW      = 8;
  localparam logic [ValW-1:0] One   = ValW'(1) << FracBits;

  localparam logic [1:0] RegSize    = 2'd0;
  localparam logic [1:0] RegEpsilon = 2'd1;
  localparam logic [1:0] RegMaxPow  = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StCopy,
    StMul,
    StCheck,
    StBack,
    StEmit
  } state_e;

  typedef struct packed {
    logic copy_base;
    logic mul_step;
    logic check;
    logic copy_back;
    logic emit_step;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic mul_done;
    logic emit_done;
    logic conv;
    logic limit;
  } stat_t;

endpackage

FILE: sv/mmpc_ctrl.sv
// controller state machine for the matrix power iteration
// depends on mmpc_pkg
module mmpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  mmpc_pkg::stat_t    stat_i,
  output mmpc_pkg::cmd_t     cmd_o,
  output logic               busy_o
);

  mmpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmpc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mmpc_pkg::StIdle:  if (go_i) state_d = mmpc_pkg::StCopy;
      mmpc_pkg::StCopy:  if (stat_i.sweep_done) state_d = mmpc_pkg::StMul;
      mmpc_pkg::StMul:   if (stat_i.mul_done) state_d = mmpc_pkg::StCheck;
      mmpc_pkg::StCheck: begin
        if (stat_i.conv || stat_i.limit) state_d = mmpc_pkg::StEmit;
        else state_d = mmpc_pkg::StBack;
      end
      mmpc_pkg::StBack:  if (stat_i.sweep_done) state_d = mmpc_pkg::StMul;
      mmpc_pkg::StEmit:  if (stat_i.emit_done) state_d = mmpc_pkg::StIdle;
      default:           state_d = mmpc_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      mmpc_pkg::StIdle:  begin
        busy_o      = 1'b0;
        cmd_o.start = go_i;
      end
      mmpc_pkg::StCopy:  cmd_o.copy_base = 1'b1;
      mmpc_pkg::StMul:   cmd_o.mul_step  = 1'b1;
      mmpc_pkg::StCheck: cmd_o.check     = 1'b1;
      mmpc_pkg::StBack:  cmd_o.copy_back = 1'b1;
      mmpc_pkg::StEmit:  cmd_o.emit_step = 1'b1;
      default:           cmd_o = '0;
    endcase
  end

endmodule

FILE: sv/mmpc_dp.sv
// datapath: base, previous and current matrices, one mac, l1 distance, output stage
// depends on mmpc_pkg
module mmpc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mmpc_pkg::cmd_t                cmd_i,
  output mmpc_pkg::stat_t               stat_o,
  input  logic                          wr_i,
  input  logic [mmpc_pkg::IdxW-1:0]     wr_row_i,
  input  logic [mmpc_pkg::IdxW-1:0]     wr_col_i,
  input  logic [mmpc_pkg::ValW-1:0]     wr_val_i,
  input  logic [mmpc_pkg::SizeW-1:0]    size_i,
  input  logic [mmpc_pkg::EpsW-1:0]     eps_i,
  input  logic [mmpc_pkg::MaxPowW-1:0]  max_pow_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mmpc_pkg::IdxW-1:0]     out_row_o,
  output logic [mmpc_pkg::IdxW-1:0]     out_col_o,
  output logic [mmpc_pkg::ValW-1:0]     out_value_o,
  output logic                          out_conv_o,
  output logic [mmpc_pkg::PowW-1:0]     out_pow_o,
  output logic                          out_last_o
);

  localparam int unsigned IW = mmpc_pkg::IdxW;
  localparam int unsigned VW = mmpc_pkg::ValW;

  logic [VW-1:0] base_mem [mmpc_pkg::Cells];
  logic [VW-1:0] prev_mem [mmpc_pkg::Cells];
  logic [VW-1:0] cur_mem  [mmpc_pkg::Cells];

  logic [IW:0] n_q;
  logic [IW-1:0] i_q, j_q, k_q;
  logic [IW-1:0] i_d, j_d, k_d;
  logic [IW-1:0] ti_q, tj_q;
  logic tlk_q, tend_q, pv_q, fin_q;
  logic [mmpc_pkg::AccW-1:0] acc_q;
  logic [mmpc_pkg::DistW-1:0] dist_q;
  logic [mmpc_pkg::PowW-1:0] pow_q;
  logic conv_q;
  logic [VW-1:0] base_rd_q, a_rd_q, p_rd_q, c_rd_q;
  logic out_valid_q, out_conv_q, out_last_q;
  logic [IW-1:0] out_row_q, out_col_q;
  logic [VW-1:0] out_value_q;
  logic [mmpc_pkg::PowW-1:0] out_pow_q;

  logic [IW-1:0] nm1, rd_row;
  logic last_i, last_j, last_k;
  logic copy, active, load_out, take, issue, seq_end, done;
  logic [2*VW-1:0] prod;
  logic [mmpc_pkg::AccW-1:0] acc_new;
  logic [VW-1:0] sat;
  logic [VW-1:0] diff;

  assign nm1    = IW'(n_q - 1'b1);
  assign last_i = (i_q == nm1);
  assign last_j = (j_q == nm1);
  assign last_k = (k_q == nm1);

  // issue stage reads the stores, second stage uses the registered data
  assign copy     = cmd_i.copy_base || cmd_i.copy_back;
  assign active   = copy || cmd_i.mul_step || cmd_i.emit_step;
  assign load_out = cmd_i.emit_step && pv_q && (!out_valid_q || out_ready_i);
  assign take     = (copy || cmd_i.mul_step) ? pv_q : load_out;
  assign issue    = active && !fin_q && (!pv_q || take);
  assign seq_end  = last_i && last_j && (!cmd_i.mul_step || last_k);
  assign done     = take && tend_q;
  assign rd_row   = cmd_i.mul_step ? k_q : i_q;

  assign prod    = a_rd_q * base_rd_q;
  assign acc_new = acc_q + mmpc_pkg::AccW'(prod >> mmpc_pkg::FracBits);
  assign sat     = (acc_new > mmpc_pkg::AccW'(mmpc_pkg::One)) ? mmpc_pkg::One : VW'(acc_new);
  assign diff    = (sat >= p_rd_q) ? (sat - p_rd_q) : (p_rd_q - sat);

  always_ff @(posedge clk_i) begin
    if (wr_i) base_mem[{wr_row_i, wr_col_i}] <= wr_val_i;
    if (cmd_i.copy_base && take) prev_mem[{ti_q, tj_q}] <= base_rd_q;
    if (cmd_i.copy_back && take) prev_mem[{ti_q, tj_q}] <= c_rd_q;
    if (cmd_i.mul_step && take && tlk_q) cur_mem[{ti_q, tj_q}] <= sat;
    if (issue) begin
      base_rd_q <= base_mem[{rd_row, j_q}];
      a_rd_q    <= prev_mem[{i_q, k_q}];
      p_rd_q    <= prev_mem[{i_q, j_q}];
      c_rd_q    <= cur_mem[{i_q, j_q}];
    end
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (cmd_i.start) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end else if (issue) begin
      if (cmd_i.mul_step && !last_k) begin
        k_d = k_q + 1'b1;
      end else begin
        k_d = '0;
        if (last_j) begin
          j_d = '0;
          i_d = last_i ? '0 : i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= (IW+1)'(mmpc_pkg::MaxStates);
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      ti_q        <= '0;
      tj_q        <= '0;
      tlk_q       <= 1'b0;
      tend_q      <= 1'b0;
      pv_q        <= 1'b0;
      fin_q       <= 1'b0;
      acc_q       <= '0;
      dist_q      <= '0;
      pow_q       <= mmpc_pkg::PowW'(1);
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_conv_q  <= 1'b0;
      out_pow_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      i_q   <= i_d;
      j_q   <= j_d;
      k_q   <= k_d;
      pv_q  <= issue || (pv_q && !take);
      fin_q <= (fin_q && !done) || (issue && seq_end);
      if (cmd_i.start) begin
        if (size_i == '0) n_q <= (IW+1)'(1);
        else if (size_i > mmpc_pkg::SizeW'(mmpc_pkg::MaxStates))
          n_q <= (IW+1)'(mmpc_pkg::MaxStates);
        else n_q <= (IW+1)'(size_i);
      end
      if (issue) begin
        ti_q   <= i_q;
        tj_q   <= j_q;
        tlk_q  <= !cmd_i.mul_step || last_k;
        tend_q <= seq_end;
      end
      if (cmd_i.start) pow_q <= mmpc_pkg::PowW'(1);
      else if (copy && done) pow_q <= pow_q + 1'b1;
      if (cmd_i.start) acc_q <= '0;
      else if (cmd_i.mul_step && take) acc_q <= tlk_q ? '0 : acc_new;
      if (copy && done) dist_q <= '0;
      else if (cmd_i.mul_step && take && tlk_q) dist_q <= dist_q + mmpc_pkg::DistW'(diff);
      if (cmd_i.check) conv_q <= stat_o.conv;
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
      if (load_out) begin
        out_row_q   <= ti_q;
        out_col_q   <= tj_q;
        out_value_q <= c_rd_q;
        out_conv_q  <= conv_q;
        out_pow_q   <= pow_q;
        out_last_q  <= tend_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_conv_o  = out_conv_q;
  assign out_pow_o   = out_pow_q;
  assign out_last_o  = out_last_q;

  assign stat_o.sweep_done = copy && done;
  assign stat_o.mul_done   = cmd_i.mul_step && done;
  assign stat_o.emit_done  = cmd_i.emit_step && done;
  assign stat_o.conv       = (dist_q < mmpc_pkg::DistW'(eps_i));
  assign stat_o.limit      = (pow_q > mmpc_pkg::PowW'(max_pow_i));

endmodule

FILE: sv/markov_matrix_power_convergence.sv
// top level of the markov matrix power block: config registers, ctrl and datapath
// depends on mmpc_pkg, mmpc_ctrl, mmpc_dp
//
// usage: matrix entries arrive on the s_axis channel, one request per cycle,
// tdata = {prob, col, row}, tlast = go. the request with tlast set is stored
// and starts the iteration; s_axis_tready stays low while the block works.
// every store is read through a register: the base matrix is copied first,
// each power is computed in the single multiply-accumulate unit followed by
// a check state, and each further power first copies the power back. in the
// emit sweep results pass the read register into the output register, one per
// cycle; a stall on m_axis_tready holds the register and the read stage and
// pauses the sweep.
// results leave on m_axis as n*n requests, row by row, tlast on the final one.
// s_axis_tready rises once the final result is in the output register, even
// while it still waits for m_axis_tready.
// config writes use cfg_valid_i/cfg_ready_o with cfg_addr_i/cfg_data_i and are
// taken any time; they should only be sent while idle.
// reset returns size 8, epsilon 655, max power 100 and an empty output; the
// matrix stores are undefined until loaded.
module markov_matrix_power_convergence (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // row, col, prob
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_row, out_col, value, power_reached
  output logic        m_axis_tuser,  // converged
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [20:0] cfg_data_i
);

  logic [mmpc_pkg::SizeW-1:0]   size_q;
  logic [mmpc_pkg::EpsW-1:0]    eps_q;
  logic [mmpc_pkg::MaxPowW-1:0] max_pow_q;
  mmpc_pkg::cmd_t  cmd;
  mmpc_pkg::stat_t stat;
  logic busy, acc_in, go;
  logic [16:0] prob, pval;
  logic [mmpc_pkg::IdxW-1:0] res_row, res_col;
  logic [mmpc_pkg::ValW-1:0] res_value;
  logic [mmpc_pkg::PowW-1:0] res_pow;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= mmpc_pkg::SizeW'(8);
      eps_q     <= mmpc_pkg::EpsW'(655);
      max_pow_q <= mmpc_pkg::MaxPowW'(100);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        mmpc_pkg::RegSize:    size_q    <= cfg_data_i[3:0];
        mmpc_pkg::RegEpsilon: eps_q     <= cfg_data_i;
        mmpc_pkg::RegMaxPow:  max_pow_q <= cfg_data_i[6:0];
        default:              size_q    <= size_q;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign go     = acc_in && s_axis_tlast;
  assign prob   = s_axis_tdata[22:6];
  assign pval   = (prob > mmpc_pkg::One) ? mmpc_pkg::One : prob;

  assign m_axis_tdata = {1'b0, res_pow, res_value, res_col, res_row};

  mmpc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  mmpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .wr_i        (acc_in),
    .wr_row_i    (s_axis_tdata[2:0]),
    .wr_col_i    (s_axis_tdata[5:3]),
    .wr_val_i    (pval),
    .size_i      (size_q),
    .eps_i       (eps_q),
    .max_pow_i   (max_pow_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (res_row),
    .out_col_o   (res_col),
    .out_value_o (res_value),
    .out_conv_o  (m_axis_tuser),
    .out_pow_o   (res_pow),
    .out_last_o  (m_axis_tlast)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_step |-> !s_axis_tready)
    else $error("input accepted during iteration");

  a_pow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[30:23] >= 8'd2))
    else $error("emitted power below two");

  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy)
    else $error("go did not start the iteration");

endmodule

FILE: dv/markov_matrix_power_convergence_tb.sv
// testbench for markov_matrix_power_convergence: loads transition matrices,
// predicts every emitted power entry in a scoreboard class and checks them
// depends on mmpc_pkg and the markov_matrix_power_convergence top level
`timescale 1ns / 1ps

module markov_matrix_power_convergence_tb;

  localparam int unsigned WatchLimit = 400000;
  localparam logic [16:0] Unity = 17'h10000;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [16:0] value;
    logic        conv;
    logic [7:0]  power;
    logic        last;
  } entry_t;

  class power_scoreboard;
    logic [16:0] base [64];
    logic [3:0]  size_reg;
    logic [20:0] eps_reg;
    logic [6:0]  max_pow_reg;
    entry_t      pending [$];
    int          errors;

    function new();
      size_reg    = 4'd8;
      eps_reg     = 21'd655;
      max_pow_reg = 7'd100;
      errors      = 0;
      foreach (base[i]) base[i] = '0;
    endfunction

    function void write_reg(logic [1:0] addr, logic [20:0] data);
      case (addr)
        mmpc_pkg::RegSize:    size_reg    = data[3:0];
        mmpc_pkg::RegEpsilon: eps_reg     = data;
        mmpc_pkg::RegMaxPow:  max_pow_reg = data[6:0];
        default: ;
      endcase
    endfunction

    function void note_entry(logic [2:0] r, logic [2:0] c, logic [16:0] p, logic go);
      longint unsigned prev [64];
      longint unsigned cur [64];
      longint unsigned acc, l1_sum, a, b;
      int n, pc;
      bit conv;
      entry_t e;
      base[r * 8 + c] = (p > Unity) ? Unity : p;
      if (!go) return;
      n = (size_reg == 0) ? 1 : (size_reg > 8) ? 8 : int'(size_reg);
      foreach (prev[i]) prev[i] = base[i];
      foreach (cur[i]) cur[i] = 0;
      pc = 1;
      conv = 0;
      forever begin
        pc++;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
              acc += (prev[i * 8 + k] * base[k * 8 + j]) >> 16;
            cur[i * 8 + j] = (acc > Unity) ? Unity : acc;
          end
        l1_sum = 0;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            a = cur[i * 8 + j];
            b = prev[i * 8 + j];
            l1_sum += (a >= b) ? a - b : b - a;
          end
        if (l1_sum < eps_reg) begin
          conv = 1;
          break;
        end
        if (pc > max_pow_reg) break;
        prev = cur;
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          e.row   = 3'(i);
          e.col   = 3'(j);
          e.value = 17'(cur[i * 8 + j]);
          e.conv  = conv;
          e.power = 8'(pc);
          e.last  = (i == n - 1) && (j == n - 1);
          pending.push_back(e);
        end
    endfunction

    function void check_entry(entry_t got);
      entry_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result row %0d col %0d", got.row, got.col);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected r%0d c%0d v%0h conv%0d pow%0d last%0d,",
                    " got r%0d c%0d v%0h conv%0d pow%0d last%0d"},
                   want.row, want.col, want.value, want.conv, want.power, want.last,
                   got.row, got.col, got.value, got.conv, got.power, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [20:0] cfg_data_i = '0;

  power_scoreboard sb = new();
  bit          calm = 0;
  bit [63:0]   loaded = '0;
  int          items = 0;
  int          quiet = 0;

  always #10 clk_i = ~clk_i;

  markov_matrix_power_convergence u_top (.*);

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 8);
  endfunction

  always @(negedge clk_i) m_axis_tready <= rst_ni && !idle_now();

  always @(posedge clk_i) begin
    entry_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row   = m_axis_tdata[2:0];
      got.col   = m_axis_tdata[5:3];
      got.value = m_axis_tdata[22:6];
      got.conv  = m_axis_tuser;
      got.power = m_axis_tdata[30:23];
      got.last  = m_axis_tlast;
      sb.check_entry(got);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_entry(logic [2:0] r, logic [2:0] c, logic [16:0] p, logic go);
    @(negedge clk_i);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p, c, r};
    s_axis_tlast  <= go;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_entry(r, c, p, go);
    loaded[r * 8 + c] = 1'b1;
    items++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle();
    end_burst();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [20:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(addr, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int active_n();
    return (sb.size_reg == 0) ? 1 : (sb.size_reg > 8) ? 8 : int'(sb.size_reg);
  endfunction

  function automatic bit covered(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!loaded[i * 8 + j]) return 0;
    return 1;
  endfunction

  // full matrix load, row by row, go on the final entry
  task automatic load_matrix(int kind);
    int n;
    logic [16:0] v, rest;
    n = active_n();
    for (int i = 0; i < n; i++) begin
      rest = Unity;
      for (int j = 0; j < n; j++) begin
        case (kind)
          0: begin
            v = (j == n - 1) ? rest : 17'($urandom_range(0, rest));
            rest -= v;
          end
          1: v = 17'($urandom_range(0, 17'h1FFFF));
          2: v = (i == j) ? Unity : 17'd0;
          default: v = (j == (i + 1) % n) ? Unity : 17'd0;
        endcase
        send_entry(3'(i), 3'(j), v, (i == n - 1) && (j == n - 1));
      end
    end
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      write_reg(mmpc_pkg::RegSize, {17'($urandom), 4'($urandom_range(1, 3))});
    else if (pick < 92)
      write_reg(mmpc_pkg::RegSize, {17'($urandom), 4'($urandom_range(4, 5))});
    else
      write_reg(mmpc_pkg::RegSize, {17'($urandom), 4'($urandom_range(0, 15))});
    case ($urandom_range(0, 4))
      0: write_reg(mmpc_pkg::RegEpsilon, 21'd0);
      1: write_reg(mmpc_pkg::RegEpsilon, 21'd1048576);
      2: write_reg(mmpc_pkg::RegEpsilon, 21'($urandom_range(0, 2000)));
      default: write_reg(mmpc_pkg::RegEpsilon, 21'($urandom_range(0, 1048576)));
    endcase
    if (active_n() <= 4 && $urandom_range(0, 9) == 0)
      write_reg(mmpc_pkg::RegMaxPow, 21'd127);
    else write_reg(mmpc_pkg::RegMaxPow, 21'($urandom_range(0, 30)));
    if ($urandom_range(0, 9) == 0) write_reg(RegUnused, 21'($urandom));
  endtask

  initial begin
    int k;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // single state: zero, oversized entry, exactly one
    write_reg(mmpc_pkg::RegSize, 21'd1);
    send_entry(3'd0, 3'd0, 17'd0, 1'b1);
    settle();
    send_entry(3'd0, 3'd0, 17'h1FFFF, 1'b1);
    settle();
    send_entry(3'd0, 3'd0, Unity, 1'b1);
    settle();
    // identity converges at once, permutation with zero threshold hits the limit
    write_reg(mmpc_pkg::RegSize, 21'd2);
    load_matrix(2);
    settle();
    write_reg(mmpc_pkg::RegEpsilon, 21'd0);
    write_reg(mmpc_pkg::RegMaxPow, 21'd0);
    load_matrix(3);
    settle();
    write_reg(mmpc_pkg::RegMaxPow, 21'd2);
    send_entry(3'd1, 3'd1, 17'd12345, 1'b1);
    settle();
    write_reg(RegUnused, 21'h1FFFFF);
    write_reg(mmpc_pkg::RegSize, 21'd0);
    write_reg(mmpc_pkg::RegEpsilon, 21'd1048576);
    send_entry(3'd7, 3'd7, 17'd77, 1'b1);
    settle();

    // full size matrix with the reset size and epsilon and a lower max power
    write_reg(mmpc_pkg::RegSize, 21'd8);
    write_reg(mmpc_pkg::RegEpsilon, 21'd655);
    write_reg(mmpc_pkg::RegMaxPow, 21'd10);
    load_matrix(0);
    settle();
    write_reg(mmpc_pkg::RegSize, 21'd15);
    write_reg(mmpc_pkg::RegMaxPow, 21'd3);
    load_matrix(1);
    settle();

    k = 0;
    while (items < 500) begin
      calm = (k == 6);
      random_config();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 99) < 85) begin
          load_matrix($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
        end else begin
          repeat ($urandom_range(1, 6))
            send_entry(3'($urandom), 3'($urandom), 17'($urandom), 1'b0);
          if (covered(active_n()))
            send_entry(3'($urandom), 3'($urandom), 17'($urandom), 1'b1);
        end
      end
      settle();
      k++;
    end
    calm = 0;

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mmpc_pkg.sv
sv/mmpc_ctrl.sv
sv/mmpc_dp.sv
sv/markov_matrix_power_convergence.sv
dv/markov_matrix_power_convergence_tb.sv
